FILE: hw/rtl/stab_pkg.sv
// Shared types, constants and codes for the sensor table block.
// Used by the RAM-free datapath, the controller and the top level.
package stab_pkg;

  localparam int TableDepthDefault = 8;
  localparam int RoleCountDefault = 3;
  localparam logic [31:0] MaxAgeReset = 32'd600000;

  localparam logic [1:0] OpUpdate = 2'd0;
  localparam logic [1:0] OpAssign = 2'd1;
  localparam logic [1:0] OpSelect = 2'd2;

  localparam logic [3:0] StAdded = 4'd0;
  localparam logic [3:0] StUpdated = 4'd1;
  localparam logic [3:0] StDup = 4'd2;
  localparam logic [3:0] StNoTemp = 4'd3;
  localparam logic [3:0] StFull = 4'd4;
  localparam logic [3:0] StRoleSet = 4'd5;
  localparam logic [3:0] StNotFound = 4'd6;
  localparam logic [3:0] StSelected = 4'd7;
  localparam logic [3:0] StNone = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic act;
    logic clr_start;
    logic clr_step;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic clr_end;
    logic need_clear;
  } stat_t;

endpackage

FILE: hw/rtl/sensor_table_with_dedup_and_roles_top.sv
// Top level of the sensor table with duplicate drop and roles.
// Steps per word: scan, act, a role clear pass when a role assign with a nonzero role hits, done strobe.
// One word at a time; busy stays high through the result strobe, and results cannot be stalled.
// Synchronous active-high rst empties the table, loads the default age limit, idles the controller.
module sensor_table_with_dedup_and_roles_top #(
  parameter int TableDepth = stab_pkg::TableDepthDefault,
  parameter int RoleCount = stab_pkg::RoleCountDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         opcode,
  input  logic [47:0]        sensor_address,
  input  logic [3:0]         presence_mask,
  input  logic signed [15:0] temperature_centi,
  input  logic [13:0]        humidity_centi,
  input  logic [6:0]         battery_level,
  input  logic [7:0]         packet_number,
  input  logic signed [7:0]  signal_strength,
  input  logic [47:0]        time_now_ms,
  input  logic [1:0]         role_code,
  output logic               done,
  output logic [3:0]         status,
  output logic [2:0]         slot_index,
  output logic [47:0]        found_address,
  output logic signed [15:0] found_temperature,
  output logic [13:0]        found_humidity,
  output logic [6:0]         found_battery,
  output logic [3:0]         found_presence,
  output logic signed [7:0]  found_rssi,
  output logic [47:0]        found_last_seen,
  output logic [3:0]         entry_count
);

  stab_pkg::cmd_t  cmd;
  stab_pkg::stat_t stat;

  stab_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd), .busy(busy));

  stab_dp #(.TableDepth(TableDepth), .RoleCount(RoleCount)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .opcode(opcode), .sensor_address(sensor_address), .presence_mask(presence_mask),
    .temperature_centi(temperature_centi), .humidity_centi(humidity_centi),
    .battery_level(battery_level), .packet_number(packet_number),
    .signal_strength(signal_strength), .time_now_ms(time_now_ms), .role_code(role_code),
    .done(done), .status(status), .slot_index(slot_index), .found_address(found_address),
    .found_temperature(found_temperature), .found_humidity(found_humidity),
    .found_battery(found_battery), .found_presence(found_presence),
    .found_rssi(found_rssi), .found_last_seen(found_last_seen), .entry_count(entry_count)
  );

endmodule

FILE: hw/rtl/stab_ctrl.sv
// Controller state machine for the sensor table block.
// Depends on stab_pkg; drives the datapath through cmd_t and reads stat_t.
module stab_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  stab_pkg::stat_t  stat,
  output stab_pkg::cmd_t   cmd,
  output logic             busy
);

  stab_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stab_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      stab_pkg::S_IDLE: begin
        if (start) state_next = stab_pkg::S_SCAN;
      end
      stab_pkg::S_SCAN: begin
        if (stat.scan_end) state_next = stab_pkg::S_ACT;
      end
      stab_pkg::S_ACT: begin
        state_next = stat.need_clear ? stab_pkg::S_CLEAR : stab_pkg::S_DONE;
      end
      stab_pkg::S_CLEAR: begin
        if (stat.clr_end) state_next = stab_pkg::S_DONE;
      end
      stab_pkg::S_DONE: state_next = stab_pkg::S_IDLE;
      default: state_next = stab_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      stab_pkg::S_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
        cmd.scan_clr = start;
      end
      stab_pkg::S_SCAN: cmd.scan_step = 1'b1;
      stab_pkg::S_ACT: begin
        cmd.act = 1'b1;
        cmd.clr_start = 1'b1;
      end
      stab_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      stab_pkg::S_DONE: cmd.done = 1'b1;
      default: cmd = '0;
    endcase
  end

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    cmd.done |=> !cmd.done) else $error("done repeated");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    cmd.done |=> !busy) else $error("not idle after done");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !$past(busy) || $past(cmd.done)) else $error("load while busy");

endmodule

FILE: hw/rtl/stab_dp.sv
// Datapath for the sensor table: record registers, scan unit and result word.
// Depends on stab_pkg; steered by the controller through cmd_t.
module stab_dp #(
  parameter int TableDepth = stab_pkg::TableDepthDefault,
  parameter int RoleCount = stab_pkg::RoleCountDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  stab_pkg::cmd_t        cmd,
  output stab_pkg::stat_t       stat,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_data,
  input  logic [1:0]            opcode,
  input  logic [47:0]           sensor_address,
  input  logic [3:0]            presence_mask,
  input  logic signed [15:0]    temperature_centi,
  input  logic [13:0]           humidity_centi,
  input  logic [6:0]            battery_level,
  input  logic [7:0]            packet_number,
  input  logic signed [7:0]     signal_strength,
  input  logic [47:0]           time_now_ms,
  input  logic [1:0]            role_code,
  output logic                  done,
  output logic [3:0]            status,
  output logic [2:0]            slot_index,
  output logic [47:0]           found_address,
  output logic signed [15:0]    found_temperature,
  output logic [13:0]           found_humidity,
  output logic [6:0]            found_battery,
  output logic [3:0]            found_presence,
  output logic signed [7:0]     found_rssi,
  output logic [47:0]           found_last_seen,
  output logic [3:0]            entry_count
);

  localparam int IW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CW = $clog2(TableDepth + 1);

  logic [47:0] e_addr [TableDepth];
  logic [47:0] e_seen [TableDepth];
  logic [7:0]  e_rssi [TableDepth];
  logic [15:0] e_temp [TableDepth];
  logic [13:0] e_hum  [TableDepth];
  logic [6:0]  e_batt [TableDepth];
  logic [7:0]  e_pkt  [TableDepth];
  logic [3:0]  e_flags [TableDepth];
  logic [1:0]  e_role [TableDepth];

  logic [CW-1:0] used_count;
  logic [31:0]   max_age;
  logic [1:0]  r_op;
  logic [47:0] r_addr;
  logic [3:0]  r_mask;
  logic [15:0] r_temp;
  logic [13:0] r_hum;
  logic [6:0]  r_batt;
  logic [7:0]  r_pkt;
  logic [7:0]  r_rssi;
  logic [47:0] r_now;
  logic [1:0]  r_role;

  logic [CW-1:0] scan_i;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] cur;
  logic          match;
  logic [48:0]   age;
  logic          fresh;
  logic          role_ok;
  logic [IW-1:0] tgt;
  logic [CW-1:0] clr_i;

  assign cur = scan_i[IW-1:0];
  assign age = {1'b0, r_now} - {1'b0, e_seen[cur]};
  assign fresh = (e_seen[cur] != 48'd0) && !age[48] && (age[47:0] <= {16'd0, max_age});
  assign role_ok = ({30'd0, r_role} <= 32'(RoleCount));
  always_comb begin
    match = 1'b0;
    case (r_op)
      stab_pkg::OpSelect: match = (e_role[cur] == r_role) && e_flags[cur][0] && fresh;
      default: match = (e_addr[cur] == r_addr);
    endcase
  end

  assign stat.scan_end = (scan_i >= used_count) || hit;
  assign stat.need_clear = (r_op == stab_pkg::OpAssign) && hit && role_ok
                           && (r_role != 2'd0);
  assign stat.clr_end = (clr_i >= used_count);
  assign tgt = hit ? hit_idx : used_count[IW-1:0];
  assign done = cmd.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= stab_pkg::MaxAgeReset;
      used_count <= '0;
    end else begin
      if (cfg_we) max_age <= cfg_data;
      if (cmd.act && r_op == stab_pkg::OpUpdate && r_mask[0] && !hit
          && used_count < CW'(TableDepth))
        used_count <= used_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_op <= opcode; r_addr <= sensor_address; r_mask <= presence_mask;
      r_temp <= temperature_centi; r_hum <= humidity_centi;
      r_batt <= battery_level; r_pkt <= packet_number;
      r_rssi <= signal_strength; r_now <= time_now_ms; r_role <= role_code;
    end
    if (cmd.scan_clr) begin
      scan_i <= '0;
      hit <= 1'b0;
      hit_idx <= '0;
    end else if (cmd.scan_step && !stat.scan_end) begin
      if (match && !(r_op == stab_pkg::OpSelect && (r_role == 2'd0 || !role_ok))) begin
        hit <= 1'b1;
        hit_idx <= cur;
      end else begin
        scan_i <= scan_i + 1'b1;
      end
    end
    if (cmd.clr_start) begin
      clr_i <= '0;
    end else if (cmd.clr_step && !stat.clr_end) begin
      if (clr_i[IW-1:0] != hit_idx && e_role[clr_i[IW-1:0]] == r_role)
        e_role[clr_i[IW-1:0]] <= 2'd0;
      clr_i <= clr_i + 1'b1;
    end
    if (cmd.act) begin
      found_address <= '0; found_temperature <= '0; found_humidity <= '0;
      found_battery <= '0; found_presence <= '0; found_rssi <= '0;
      found_last_seen <= '0;
      status <= stab_pkg::StNotFound;
      slot_index <= '0;
      case (r_op)
        stab_pkg::OpUpdate: begin
          if (!r_mask[0]) begin
            status <= stab_pkg::StNoTemp;
          end else if (!hit && used_count >= CW'(TableDepth)) begin
            status <= stab_pkg::StFull;
          end else begin
            slot_index <= 3'(tgt);
            e_seen[tgt] <= r_now;
            e_rssi[tgt] <= r_rssi;
            if (hit && r_mask[3] && e_flags[tgt][3] && e_pkt[tgt] == r_pkt) begin
              status <= stab_pkg::StDup;
            end else begin
              e_temp[tgt] <= r_temp;
              if (r_mask[1]) e_hum[tgt] <= r_hum;
              else if (!hit) e_hum[tgt] <= '0;
              if (r_mask[2]) e_batt[tgt] <= r_batt;
              else if (!hit) e_batt[tgt] <= '0;
              if (r_mask[3]) e_pkt[tgt] <= r_pkt;
              else if (!hit) e_pkt[tgt] <= '0;
              e_flags[tgt] <= (hit ? e_flags[tgt] : 4'd0) | r_mask;
              status <= hit ? stab_pkg::StUpdated : stab_pkg::StAdded;
            end
            if (!hit) begin
              e_addr[tgt] <= r_addr;
              e_role[tgt] <= 2'd0;
            end
          end
        end
        stab_pkg::OpAssign: begin
          if (hit && role_ok) begin
            e_role[hit_idx] <= r_role;
            status <= stab_pkg::StRoleSet;
            slot_index <= 3'(hit_idx);
          end
        end
        stab_pkg::OpSelect: begin
          status <= stab_pkg::StNone;
          if (hit) begin
            status <= stab_pkg::StSelected;
            slot_index <= 3'(hit_idx);
            found_address <= e_addr[hit_idx];
            found_temperature <= e_temp[hit_idx];
            found_humidity <= e_hum[hit_idx];
            found_battery <= e_batt[hit_idx];
            found_presence <= e_flags[hit_idx];
            found_rssi <= e_rssi[hit_idx];
            found_last_seen <= e_seen[hit_idx];
          end
        end
        default: status <= stab_pkg::StNotFound;
      endcase
    end
  end

  assign entry_count = 4'(used_count);

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(TableDepth)) else $error("count overflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !cmd.act |=> used_count == $past(used_count)) else $error("count moved");
  a_hit_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.act && hit) |-> ({1'b0, hit_idx} < {1'b0, used_count})) else $error("bad hit");

endmodule
